[rtl/core/cbe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared constants, types and helpers for the cubic Bezier easing block.
// ----------------------------------------------------------------------------
package cbe_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int QW            = FRAC_BITS + 1;
   localparam int IFRAC         = 30;
   localparam int TW            = IFRAC + 1;
   localparam int IW            = 40;
   localparam int SH            = IFRAC - FRAC_BITS;
   localparam int SAMPLE_POINTS = 11;
   localparam int NEWTON_STEPS  = 8;
   localparam int SIDX_W        = $clog2(SAMPLE_POINTS);
   localparam int NCNT_W        = $clog2(NEWTON_STEPS + 1);
   localparam int MUL_LO        = IW / 2;
   localparam int MUL_HI        = IW - MUL_LO;
   localparam int PROD_W        = IW + TW;
   localparam int MAG_W         = 64;
   localparam int DCNT_W        = $clog2(MAG_W + 1);
   localparam int SAT_BIT       = IW - 2;
   localparam int CSR_IDX_W     = 4;

   localparam logic [QW-1:0] QONE = QW'(1) << FRAC_BITS;
   localparam logic [TW-1:0] IONE = TW'(1) << IFRAC;

   localparam logic [CSR_IDX_W-1:0] REG_CTRL1_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_CTRL1_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_CTRL2_X = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_CTRL2_Y = CSR_IDX_W'(3);

   localparam logic [QW-1:0] CTRL1_X_RESET = QW'(16384);
   localparam logic [QW-1:0] CTRL1_Y_RESET = QW'(6554);
   localparam logic [QW-1:0] CTRL2_X_RESET = QW'(16384);
   localparam logic [QW-1:0] CTRL2_Y_RESET = QW'(65536);

   typedef logic [TW-1:0] samp_t_arr_type [SAMPLE_POINTS];

   function automatic samp_t_arr_type gen_sample_t();
      samp_t_arr_type r;
      longint v;
      for (int i = 0; i < SAMPLE_POINTS; i++) begin
         v = (longint'(i) * (longint'(1) << IFRAC) + (SAMPLE_POINTS - 1) / 2)
             / (SAMPLE_POINTS - 1);
         r[i] = TW'(v);
      end
      return r;
   endfunction

   localparam samp_t_arr_type SAMPLE_T = gen_sample_t();

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EV_M1,
      ST_EV_M2,
      ST_EV_M3,
      ST_EV_M4,
      ST_SAMP_CHK,
      ST_LIN_CHK,
      ST_LIN_MUL,
      ST_LIN_DIV,
      ST_NEWT_CHK,
      ST_NEWT_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {PH_SAMPLE, PH_NEWTON, PH_EASE} phase_type;

   typedef enum logic [1:0] {MS_IDLE, MS_LO, MS_HI} mul_stage_type;

   typedef struct packed {
      logic [QW-1:0] ctrl1_x;
      logic [QW-1:0] ctrl1_y;
      logic [QW-1:0] ctrl2_x;
      logic [QW-1:0] ctrl2_y;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic signed [IW-1:0] a;
      logic [TW-1:0]        b;
   } mul_req_type;

   typedef struct packed {
      logic                 done;
      logic                 neg;
      logic [PROD_W-1:0]    prod;
      logic signed [IW-1:0] rnd;
   } mul_rsp_type;

   typedef struct packed {
      logic             start;
      logic             n_neg;
      logic [MAG_W-1:0] n_mag;
      logic             d_neg;
      logic [IW-1:0]    d_mag;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic signed [IW-1:0] quo;
   } div_rsp_type;

   typedef struct packed {
      logic signed [IW-1:0] a;
      logic signed [IW-1:0] b;
      logic signed [IW-1:0] c;
   } poly_type;

   function automatic logic signed [IW-1:0] to_internal(input logic [QW-1:0] v);
      logic [QW-1:0] c;
      c = (v > QONE) ? QONE : v;
      return $signed(IW'(c) << SH);
   endfunction

   function automatic poly_type make_poly(input logic signed [IW-1:0] p1,
                                          input logic signed [IW-1:0] p2);
      poly_type r;
      r.c = p1 + (p1 <<< 1);
      r.b = p2 + (p2 <<< 1) - (p1 <<< 1) - (p1 <<< 2);
      r.a = $signed(IW'(IONE)) - r.c - r.b;
      return r;
   endfunction

   function automatic logic [TW-1:0] clamp_unit(input logic signed [IW:0] v);
      logic [TW-1:0] r;
      if (v[IW])
         r = '0;
      else if (v[IW-1:0] > IW'(IONE))
         r = IONE;
      else
         r = v[TW-1:0];
      return r;
   endfunction

endpackage

[rtl/core/cbe_intf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_intf
// Request, response and register-write channels of the easing block.
// ----------------------------------------------------------------------------
interface cbe_req_if;
   import cbe_pkg::*;
   logic          valid;
   logic          ready;
   logic [QW-1:0] progress_in;
   modport source (output valid, output progress_in, input ready);
   modport sink (input valid, input progress_in, output ready);
endinterface

interface cbe_rsp_if;
   import cbe_pkg::*;
   logic          valid;
   logic          ready;
   logic [QW-1:0] eased_out;
   modport source (output valid, output eased_out, input ready);
   modport sink (input valid, input eased_out, output ready);
endinterface

interface cbe_csr_if;
   import cbe_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [QW-1:0]        data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/cbe_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_mul
// Shared signed-by-unsigned multiplier, two half-width passes, Q30 rounding.
// ----------------------------------------------------------------------------
module cbe_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  cbe_pkg::mul_req_type mul_req,
   output cbe_pkg::mul_rsp_type mul_rsp
);
   import cbe_pkg::*;

   localparam logic [PROD_W:0] RHALF = (PROD_W + 1)'(1) << (IFRAC - 1);

   mul_stage_type           stage_ff, stage_in;
   logic                    done_ff, done_in;
   logic                    neg_ff, neg_in;
   logic [IW-1:0]           mag_ff, mag_in;
   logic [TW-1:0]           b_ff, b_in;
   logic [MUL_LO+TW-1:0]    lo_ff, lo_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [MUL_HI-1:0]       half;
   logic [MUL_HI+TW-1:0]    part_p;
   logic [PROD_W:0]         rsum;
   logic [IW-1:0]           rmag;

   always_comb begin
      stage_in = stage_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      b_in     = b_ff;
      lo_in    = lo_ff;
      prod_in  = prod_ff;
      half     = (stage_ff == MS_LO) ? MUL_HI'(mag_ff[MUL_LO-1:0]) : mag_ff[IW-1:MUL_LO];
      part_p   = half * b_ff;
      case (stage_ff)
         MS_IDLE: begin
            if (mul_req.start) begin
               neg_in   = mul_req.a[IW-1];
               mag_in   = mul_req.a[IW-1] ? IW'(-mul_req.a) : IW'(mul_req.a);
               b_in     = mul_req.b;
               stage_in = MS_LO;
            end
         end
         MS_LO: begin
            lo_in    = (MUL_LO + TW)'(part_p);
            stage_in = MS_HI;
         end
         MS_HI: begin
            prod_in  = PROD_W'(lo_ff) + (PROD_W'(part_p) << MUL_LO);
            done_in  = 1'b1;
            stage_in = MS_IDLE;
         end
         default: stage_in = MS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= MS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      b_ff    <= b_in;
      lo_ff   <= lo_in;
      prod_ff <= prod_in;
   end

   assign rsum         = {1'b0, prod_ff} + RHALF;
   assign rmag         = rsum[IFRAC +: IW];
   assign mul_rsp.done = done_ff;
   assign mul_rsp.neg  = neg_ff;
   assign mul_rsp.prod = prod_ff;
   assign mul_rsp.rnd  = neg_ff ? -$signed(rmag) : $signed(rmag);

endmodule

[rtl/core/cbe_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_div
// Shared radix-2 restoring divider, sign-magnitude, truncating, saturated.
// ----------------------------------------------------------------------------
module cbe_div (
   input  logic                 clock,
   input  logic                 reset,
   input  cbe_pkg::div_req_type div_req,
   output cbe_pkg::div_rsp_type div_rsp
);
   import cbe_pkg::*;

   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  num_ff, num_in;
   logic [IW-1:0]     den_ff, den_in;
   logic [IW:0]       rem_ff, rem_in;
   logic [IW:0]       rem_sh;
   logic              ge;
   logic              sat;
   logic [IW-1:0]     qmag;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff[IW-1:0], num_ff[MAG_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      if (cnt_ff == '0) begin
         if (div_req.start) begin
            num_in = div_req.n_mag;
            den_in = div_req.d_mag;
            rem_in = '0;
            neg_in = div_req.n_neg ^ div_req.d_neg;
            cnt_in = DCNT_W'(MAG_W);
         end
      end else begin
         rem_in  = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         num_in  = {num_ff[MAG_W-2:0], ge};
         cnt_in  = cnt_ff - DCNT_W'(1);
         done_in = (cnt_ff == DCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   // quotients of 2**SAT_BIT (256.0 in Q30) and above all clamp to that value
   assign sat          = |num_ff[MAG_W-1:SAT_BIT];
   assign qmag         = sat ? (IW'(1) << SAT_BIT) : IW'(num_ff[SAT_BIT-1:0]);
   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = neg_ff ? -$signed(qmag) : $signed(qmag);

endmodule

[rtl/core/cbe_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_ctrl
// Sequencer: curve sampling, bracketing, linear guess, Newton steps, output.
// ----------------------------------------------------------------------------
module cbe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  cbe_pkg::cfg_type     cfg,
   cbe_req_if.sink              req_if,
   cbe_rsp_if.source            rsp_if,
   output cbe_pkg::mul_req_type mul_req,
   input  cbe_pkg::mul_rsp_type mul_rsp,
   output cbe_pkg::div_req_type div_req,
   input  cbe_pkg::div_rsp_type div_rsp
);
   import cbe_pkg::*;

   localparam logic [TW-1:0] YHALF = TW'(1) << (SH - 1);

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic                 wait_ff, wait_in;
   logic                 sel_y_ff, sel_y_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [QW-1:0]        rsp_data_ff, rsp_data_in;
   logic signed [IW-1:0] x_ff, x_in;
   logic [TW-1:0]        t_ff, t_in;
   logic [TW-1:0]        base_ff, base_in;
   logic signed [IW-1:0] m1_ff, m1_in;
   logic signed [IW-1:0] acc_ff, acc_in;
   logic signed [IW-1:0] e_ff, e_in;
   logic signed [IW-1:0] d_ff, d_in;
   logic signed [IW-1:0] prev_ff, prev_in;
   logic signed [IW-1:0] x0_ff, x0_in;
   logic signed [IW-1:0] x1_ff, x1_in;
   logic [IW-1:0]        dx_ff, dx_in;
   logic [SIDX_W-1:0]    i_ff, i_in;
   logic [SIDX_W-1:0]    idx_ff, idx_in;
   logic [NCNT_W-1:0]    ncnt_ff, ncnt_in;
   logic                 pneg_ff, pneg_in;
   logic [MAG_W-1:0]     pmag_ff, pmag_in;

   poly_type             px, py, pc;
   logic signed [IW:0]   err;
   logic [IW:0]          err_abs;
   logic signed [IW:0]   dxs;
   logic signed [IW-1:0] slope_a;
   logic [TW-1:0]        t0, t1, ysat, ysum;
   logic                 mul_state, div_state;

   always_comb begin
      px      = make_poly(to_internal(cfg.ctrl1_x), to_internal(cfg.ctrl2_x));
      py      = make_poly(to_internal(cfg.ctrl1_y), to_internal(cfg.ctrl2_y));
      pc      = sel_y_ff ? py : px;
      err     = {e_ff[IW-1], e_ff} - {x_ff[IW-1], x_ff};
      err_abs = err[IW] ? (IW + 1)'(-err) : (IW + 1)'(err);
      dxs     = {x1_ff[IW-1], x1_ff} - {x0_ff[IW-1], x0_ff};
      slope_a = m1_ff + (m1_ff <<< 1) + (pc.b <<< 1);
      t0      = SAMPLE_T[idx_ff];
      t1      = SAMPLE_T[idx_ff + SIDX_W'(1)];
      ysat    = clamp_unit({mul_rsp.rnd[IW-1], mul_rsp.rnd});
      ysum    = ysat + YHALF;

      mul_state = (state_ff == ST_EV_M1) || (state_ff == ST_EV_M2) ||
                  (state_ff == ST_EV_M3) || (state_ff == ST_EV_M4) ||
                  (state_ff == ST_LIN_MUL);
      div_state = (state_ff == ST_LIN_DIV) || (state_ff == ST_NEWT_DIV);
      wait_in   = (mul_state && !mul_rsp.done) || (div_state && !div_rsp.done);

      mul_req.start = mul_state && !wait_ff;
      mul_req.b     = t_ff;
      case (state_ff)
         ST_EV_M1:   mul_req.a = pc.a;
         ST_EV_M4:   mul_req.a = slope_a;
         ST_LIN_MUL: begin
            mul_req.a = x_ff - x0_ff;
            mul_req.b = t1 - t0;
         end
         default:    mul_req.a = acc_ff;
      endcase

      div_req.start = div_state && !wait_ff;
      if (state_ff == ST_LIN_DIV) begin
         div_req.n_neg = pneg_ff;
         div_req.n_mag = pmag_ff;
         div_req.d_neg = 1'b0;
         div_req.d_mag = dx_ff;
      end else begin
         div_req.n_neg = err[IW];
         div_req.n_mag = MAG_W'(err_abs) << IFRAC;
         div_req.d_neg = d_ff[IW-1];
         div_req.d_mag = d_ff[IW-1] ? IW'(-d_ff) : IW'(d_ff);
      end

      state_in     = state_ff;
      phase_in     = phase_ff;
      sel_y_in     = sel_y_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      x_in         = x_ff;
      t_in         = t_ff;
      base_in      = base_ff;
      m1_in        = m1_ff;
      acc_in       = acc_ff;
      e_in         = e_ff;
      d_in         = d_ff;
      prev_in      = prev_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      dx_in        = dx_ff;
      i_in         = i_ff;
      idx_in       = idx_ff;
      ncnt_in      = ncnt_ff;
      pneg_in      = pneg_ff;
      pmag_in      = pmag_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               x_in     = to_internal(req_if.progress_in);
               t_in     = SAMPLE_T[0];
               i_in     = '0;
               phase_in = PH_SAMPLE;
               sel_y_in = 1'b0;
               state_in = ST_EV_M1;
            end
         end
         ST_EV_M1: begin
            if (mul_rsp.done) begin
               m1_in    = mul_rsp.rnd;
               acc_in   = mul_rsp.rnd + pc.b;
               state_in = ST_EV_M2;
            end
         end
         ST_EV_M2: begin
            if (mul_rsp.done) begin
               acc_in   = mul_rsp.rnd + pc.c;
               state_in = ST_EV_M3;
            end
         end
         ST_EV_M3: begin
            if (mul_rsp.done) begin
               e_in = mul_rsp.rnd;
               case (phase_ff)
                  PH_NEWTON: state_in = ST_EV_M4;
                  PH_SAMPLE: state_in = ST_SAMP_CHK;
                  PH_EASE: begin
                     rsp_data_in  = ysum[SH +: QW];
                     rsp_valid_in = 1'b1;
                     state_in     = ST_OUT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EV_M4: begin
            if (mul_rsp.done) begin
               d_in     = mul_rsp.rnd + pc.c;
               state_in = ST_NEWT_CHK;
            end
         end
         ST_SAMP_CHK: begin
            if (i_ff == '0) begin
               prev_in  = e_ff;
               i_in     = SIDX_W'(1);
               t_in     = SAMPLE_T[1];
               state_in = ST_EV_M1;
            end else if ((i_ff == SIDX_W'(SAMPLE_POINTS - 1)) || (e_ff > x_ff)) begin
               x0_in    = prev_ff;
               x1_in    = e_ff;
               idx_in   = i_ff - SIDX_W'(1);
               state_in = ST_LIN_CHK;
            end else begin
               prev_in  = e_ff;
               i_in     = i_ff + SIDX_W'(1);
               t_in     = SAMPLE_T[i_ff + SIDX_W'(1)];
               state_in = ST_EV_M1;
            end
         end
         ST_LIN_CHK: begin
            base_in = t0;
            dx_in   = dxs[IW-1:0];
            if (!dxs[IW] && (dxs[IW-1:0] > IW'(1))) begin
               state_in = ST_LIN_MUL;
            end else begin
               t_in     = t0;
               ncnt_in  = '0;
               phase_in = PH_NEWTON;
               state_in = ST_EV_M1;
            end
         end
         ST_LIN_MUL: begin
            if (mul_rsp.done) begin
               pneg_in  = mul_rsp.neg;
               pmag_in  = mul_rsp.prod[MAG_W-1:0];
               state_in = ST_LIN_DIV;
            end
         end
         ST_LIN_DIV: begin
            if (div_rsp.done) begin
               t_in     = clamp_unit($signed((IW + 1)'(base_ff)) +
                                     {div_rsp.quo[IW-1], div_rsp.quo});
               ncnt_in  = '0;
               phase_in = PH_NEWTON;
               state_in = ST_EV_M1;
            end
         end
         ST_NEWT_CHK: begin
            if ((err == '0) || (d_ff == '0)) begin
               sel_y_in = 1'b1;
               phase_in = PH_EASE;
               state_in = ST_EV_M1;
            end else begin
               state_in = ST_NEWT_DIV;
            end
         end
         ST_NEWT_DIV: begin
            if (div_rsp.done) begin
               t_in     = clamp_unit($signed((IW + 1)'(t_ff)) -
                                     {div_rsp.quo[IW-1], div_rsp.quo});
               state_in = ST_EV_M1;
               if (ncnt_ff == NCNT_W'(NEWTON_STEPS - 1)) begin
                  sel_y_in = 1'b1;
                  phase_in = PH_EASE;
               end else begin
                  ncnt_in = ncnt_ff + NCNT_W'(1);
               end
            end
         end
         ST_OUT: begin
            if (rsp_if.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SAMPLE;
         wait_ff      <= 1'b0;
         sel_y_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ncnt_ff      <= '0;
         i_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         sel_y_ff     <= sel_y_in;
         rsp_valid_ff <= rsp_valid_in;
         ncnt_ff      <= ncnt_in;
         i_ff         <= i_in;
      end
      rsp_data_ff <= rsp_data_in;
      x_ff        <= x_in;
      t_ff        <= t_in;
      base_ff     <= base_in;
      m1_ff       <= m1_in;
      acc_ff      <= acc_in;
      e_ff        <= e_in;
      d_ff        <= d_in;
      prev_ff     <= prev_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      dx_ff       <= dx_in;
      idx_ff      <= idx_in;
      pneg_ff     <= pneg_in;
      pmag_ff     <= pmag_in;
   end

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.eased_out = rsp_data_ff;

`ifndef SYNTHESIS
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_req.start && div_req.start))
      else $error("multiplier and divider started together");
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_OUT))
      else $error("response valid outside output state");
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (t_ff <= IONE))
      else $error("curve parameter out of range");
   a_mul_issued: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> wait_ff)
      else $error("multiplier result without a pending request");
`endif

endmodule

[rtl/core/cubic_bezier_ease_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_ease_top
// Cubic Bezier easing curve y(x) with configurable inner control points.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake     Payload
// req_if    in   valid/ready   progress_in  [16:0] Q16 x
// rsp_if    out  valid/ready   eased_out    [16:0] Q16 y
// csr_if    in   valid/ready   index [3:0], data [16:0]
//
// One request at a time: each curve sample takes three passes of the shared
// multiplier, the linear guess (skipped for a narrow bracket) one multiply
// and a divide, each Newton step four multiplies and a divide, and the eased
// value three multiplies before the output state. The divider's bit-serial
// loop sets most of the time per request.
// Reset is synchronous; the control points return to their defaults.
// req_if.ready is low from acceptance until the response is taken.
// ----------------------------------------------------------------------------
module cubic_bezier_ease_top (
   input  logic      clock,
   input  logic      reset,
   cbe_req_if.sink   req_if,
   cbe_rsp_if.source rsp_if,
   cbe_csr_if.sink   csr_if
);
   import cbe_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            REG_CTRL1_X: cfg_in.ctrl1_x = csr_if.data;
            REG_CTRL1_Y: cfg_in.ctrl1_y = csr_if.data;
            REG_CTRL2_X: cfg_in.ctrl2_x = csr_if.data;
            REG_CTRL2_Y: cfg_in.ctrl2_y = csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ctrl1_x <= CTRL1_X_RESET;
         cfg_ff.ctrl1_y <= CTRL1_Y_RESET;
         cfg_ff.ctrl2_x <= CTRL2_X_RESET;
         cfg_ff.ctrl2_y <= CTRL2_Y_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_if.ready = 1'b1;

   cbe_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   cbe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   cbe_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule
